>>> hdl/g2e_pkg.sv
// g2e_pkg: shared constants, types and the arctangent table for the
// geodetic to earth-centred conversion pipeline
// no dependencies

package g2e_pkg;

	// rotation unit sizing
	localparam int CORDIC_STEPS = 28;
	localparam int ANG_W        = 32;
	localparam int TRIG_W       = 32;
	localparam int XY_W         = 33;

	// angle constants in units of 1e-7 degree
	localparam logic signed [33:0] FULL_TURN    = 34'sd3600000000;
	localparam logic signed [33:0] HALF_TURN    = 34'sd1800000000;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;

	// rotation start vector and clamp limit, q30
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [XY_W:0]   ONE_Q30     = 34'sd1073741824;

	// ellipsoid eccentricity squared, q32
	localparam logic [24:0] E2_Q32 = 25'd28752143;

	// root and radius units
	localparam int SQRT_STEPS = 31;
	localparam int ROOT_W     = 31;
	localparam int DIV_STEPS  = 33;
	localparam int RAD_W      = 33;
	localparam logic [63:0] RAD_NUM = 64'd637813700 << 33;

	// output scaling: offset in eighths of a centimetre, divide by 800
	localparam logic signed [35:0] OFFSET_EIGHTHS = 36'sd5102509600;
	localparam logic [30:0]        RECIP_25       = 31'd1374389534;
	localparam int                 RECIP_SHIFT    = 35;
	localparam logic signed [26:0] OUT_LOW        = -27'sd1048576;
	localparam logic signed [26:0] OUT_HIGH       = 27'sd16777215;

	// pipeline stage numbers
	localparam int ST_TRIG = 30;
	localparam int ST_ROOT = 96;
	localparam int LAT     = 102;

	typedef struct packed {
		logic signed [TRIG_W-1:0] clat;
		logic signed [TRIG_W-1:0] slat;
		logic signed [TRIG_W-1:0] clon;
		logic signed [TRIG_W-1:0] slon;
	} trig_t;

	// rounded arctangent of 2^-i in 1e-7 degree
	function automatic logic [28:0] atan_1e7deg(input int i);
		logic [28:0] r;
		case (i)
			0:       r = 29'd450000000;
			1:       r = 29'd265650512;
			2:       r = 29'd140362435;
			3:       r = 29'd71250163;
			4:       r = 29'd35763344;
			5:       r = 29'd17899106;
			6:       r = 29'd8951737;
			7:       r = 29'd4476142;
			8:       r = 29'd2238105;
			9:       r = 29'd1119057;
			10:      r = 29'd559529;
			11:      r = 29'd279765;
			12:      r = 29'd139882;
			13:      r = 29'd69941;
			14:      r = 29'd34971;
			15:      r = 29'd17485;
			16:      r = 29'd8743;
			17:      r = 29'd4371;
			18:      r = 29'd2186;
			19:      r = 29'd1093;
			20:      r = 29'd546;
			21:      r = 29'd273;
			22:      r = 29'd137;
			23:      r = 29'd68;
			24:      r = 29'd34;
			25:      r = 29'd17;
			26:      r = 29'd9;
			27:      r = 29'd4;
			default: r = 29'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/g2e_cordic.sv
// g2e_cordic: pipelined sine and cosine of an angle in 1e-7 degree, q30 results
// one angle reduction stage, one stage per rotation, one fold and clamp stage
// depends on g2e_pkg

module g2e_cordic (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [g2e_pkg::ANG_W-1:0]      angle,
	output logic signed [g2e_pkg::TRIG_W-1:0]     cos_q30,
	output logic signed [g2e_pkg::TRIG_W-1:0]     sin_q30
);

	logic signed [33:0] a_ext;
	logic signed [33:0] a_wrap;
	logic signed [33:0] a_fold;
	logic               fold;

	logic signed [g2e_pkg::XY_W-1:0]  x_s    [0:g2e_pkg::CORDIC_STEPS];
	logic signed [g2e_pkg::XY_W-1:0]  y_s    [0:g2e_pkg::CORDIC_STEPS];
	logic signed [g2e_pkg::ANG_W-1:0] z_s    [0:g2e_pkg::CORDIC_STEPS];
	logic                             flip_s [0:g2e_pkg::CORDIC_STEPS];

	logic signed [g2e_pkg::XY_W:0] xf;
	logic signed [g2e_pkg::XY_W:0] yf;
	logic signed [g2e_pkg::TRIG_W-1:0] cos_s30;
	logic signed [g2e_pkg::TRIG_W-1:0] sin_s30;

	// wrap into (-180, 180] then fold into [-90, 90]
	always_comb begin
		a_ext = 34'(angle);
		if (a_ext > g2e_pkg::HALF_TURN) begin
			a_wrap = a_ext - g2e_pkg::FULL_TURN;
		end else if (a_ext <= -g2e_pkg::HALF_TURN) begin
			a_wrap = a_ext + g2e_pkg::FULL_TURN;
		end else begin
			a_wrap = a_ext;
		end
		fold = 1'b1;
		if (a_wrap > g2e_pkg::QUARTER_TURN) begin
			a_fold = a_wrap - g2e_pkg::HALF_TURN;
		end else if (a_wrap < -g2e_pkg::QUARTER_TURN) begin
			a_fold = a_wrap + g2e_pkg::HALF_TURN;
		end else begin
			a_fold = a_wrap;
			fold = 1'b0;
		end
	end

	// reduction stage
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= g2e_pkg::CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= a_fold[g2e_pkg::ANG_W-1:0];
			flip_s[0] <= fold;
		end
	end

	// rotation stages
	for (genvar i = 0; i < g2e_pkg::CORDIC_STEPS; i++) begin : g_rot
		logic signed [g2e_pkg::XY_W-1:0]  dx;
		logic signed [g2e_pkg::XY_W-1:0]  dy;
		logic signed [g2e_pkg::ANG_W-1:0] step;
		assign dx   = y_s[i] >>> i;
		assign dy   = x_s[i] >>> i;
		assign step = g2e_pkg::ANG_W'(g2e_pkg::atan_1e7deg(i));

		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][g2e_pkg::ANG_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - step;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + step;
				end
			end
		end
	end

	// undo the half-turn fold and clamp to unit range
	always_comb begin
		xf = flip_s[g2e_pkg::CORDIC_STEPS] ? -(34'(x_s[g2e_pkg::CORDIC_STEPS]))
		                                   : 34'(x_s[g2e_pkg::CORDIC_STEPS]);
		yf = flip_s[g2e_pkg::CORDIC_STEPS] ? -(34'(y_s[g2e_pkg::CORDIC_STEPS]))
		                                   : 34'(y_s[g2e_pkg::CORDIC_STEPS]);
		if (xf > g2e_pkg::ONE_Q30) begin
			xf = g2e_pkg::ONE_Q30;
		end else if (xf < -g2e_pkg::ONE_Q30) begin
			xf = -g2e_pkg::ONE_Q30;
		end
		if (yf > g2e_pkg::ONE_Q30) begin
			yf = g2e_pkg::ONE_Q30;
		end else if (yf < -g2e_pkg::ONE_Q30) begin
			yf = -g2e_pkg::ONE_Q30;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s30 <= xf[g2e_pkg::TRIG_W-1:0];
			sin_s30 <= yf[g2e_pkg::TRIG_W-1:0];
		end
	end

	assign cos_q30 = cos_s30;
	assign sin_q30 = sin_s30;

endmodule

>>> hdl/g2e_root_div.sv
// g2e_root_div: prime-vertical radius from the q30 term 1 - e2*sin^2
// pipelined square root, one result bit a stage, then pipelined long division
// depends on g2e_pkg

module g2e_root_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [30:0]                   w_q30,
	output logic [g2e_pkg::RAD_W-1:0]     radius
);

	logic [61:0] v_s [1:g2e_pkg::SQRT_STEPS];
	logic [61:0] r_s [1:g2e_pkg::SQRT_STEPS];

	logic [63:0]                   rem_s [1:g2e_pkg::DIV_STEPS];
	logic [g2e_pkg::RAD_W-1:0]     q_s   [1:g2e_pkg::DIV_STEPS];
	logic [g2e_pkg::ROOT_W-1:0]    d_s   [1:g2e_pkg::DIV_STEPS];

	// square root of w << 30, digit by digit
	for (genvar i = 0; i < g2e_pkg::SQRT_STEPS; i++) begin : g_sqrt
		localparam logic [61:0] BIT = 62'(1) << (60 - 2*i);
		logic [61:0] v_cur;
		logic [61:0] r_cur;
		logic [61:0] trial;
		if (i == 0) begin : g_first
			assign v_cur = {1'b0, w_q30, 30'b0};
			assign r_cur = '0;
		end else begin : g_next
			assign v_cur = v_s[i];
			assign r_cur = r_s[i];
		end
		assign trial = r_cur + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_cur >= trial) begin
					v_s[i+1] <= v_cur - trial;
					r_s[i+1] <= (r_cur >> 1) + BIT;
				end else begin
					v_s[i+1] <= v_cur;
					r_s[i+1] <= r_cur >> 1;
				end
			end
		end
	end

	// constant numerator over the root, one quotient bit a stage
	for (genvar j = 0; j < g2e_pkg::DIV_STEPS; j++) begin : g_div
		localparam int K = g2e_pkg::DIV_STEPS - 1 - j;
		logic [63:0]                rem_cur;
		logic [g2e_pkg::RAD_W-1:0]  q_cur;
		logic [g2e_pkg::ROOT_W-1:0] d_cur;
		logic [63:0]                dsh;
		if (j == 0) begin : g_first
			assign rem_cur = g2e_pkg::RAD_NUM;
			assign q_cur   = '0;
			assign d_cur   = r_s[g2e_pkg::SQRT_STEPS][g2e_pkg::ROOT_W-1:0];
		end else begin : g_next
			assign rem_cur = rem_s[j];
			assign q_cur   = q_s[j];
			assign d_cur   = d_s[j];
		end
		assign dsh = 64'(d_cur) << K;

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j+1] <= d_cur;
				if (rem_cur >= dsh) begin
					rem_s[j+1] <= rem_cur - dsh;
					q_s[j+1]   <= q_cur | (g2e_pkg::RAD_W'(1) << K);
				end else begin
					rem_s[j+1] <= rem_cur;
					q_s[j+1]   <= q_cur;
				end
			end
		end
	end

	assign radius = q_s[g2e_pkg::DIV_STEPS];

endmodule

>>> hdl/geodetic_to_ecef_offset.sv
// geodetic_to_ecef_offset: top level of the geodetic to earth-centred converter
// depends on g2e_pkg, g2e_cordic and g2e_root_div
//
// Converts one track point (latitude, longitude in 1e-7 degree, height in cm)
// to earth-centred x, y, z on the WGS84 ellipsoid, each plus the semi-major
// axis, in whole metres truncated toward zero and saturated to
// [-1048576, 16777215]. A point is taken every clock cycle while no result
// is held at the output; the pipeline is made up mainly of the 28 rotation
// stages of the sine/cosine units, the 31 stages of the square root and the 33
// stages of the radius division. The whole pipeline holds while a result waits
// at the output, so back-pressure costs no points. No state is kept between
// points.

module geodetic_to_ecef_offset (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// latitude [30:0], longitude [62:31], height [83:63], zero fill [87:84]
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// x_offset [24:0], y_offset [49:25], z_offset [74:50], zero fill [79:75]
	output logic [79:0] m_axis_tdata
);

	logic adv;
	logic vld_q [1:g2e_pkg::LAT];

	logic signed [30:0] lat_in;
	logic signed [31:0] lon_in;
	logic signed [20:0] h_in;

	logic signed [g2e_pkg::TRIG_W-1:0] clat;
	logic signed [g2e_pkg::TRIG_W-1:0] slat;
	logic signed [g2e_pkg::TRIG_W-1:0] clon;
	logic signed [g2e_pkg::TRIG_W-1:0] slon;

	logic signed [20:0]  h_s    [1:g2e_pkg::ST_ROOT];
	g2e_pkg::trig_t      trig_s [g2e_pkg::ST_TRIG+1:98];

	logic [30:0]         abs_s;
	logic [61:0]         sq_full;
	logic [30:0]         s2_s31;
	logic [55:0]         e2s_full;
	logic [30:0]         w_s32;
	logic [g2e_pkg::RAD_W-1:0] n_rad;

	logic signed [34:0]  prad_s97;
	logic [57:0]         ne2_s97;
	logic [g2e_pkg::RAD_W-1:0] n_s97;
	logic signed [23:0]  h8_s97;

	logic signed [34:0]  zrad;
	logic signed [66:0]  rprod_s98;
	logic signed [66:0]  zprod_s98;

	logic signed [34:0]  rho;
	logic signed [66:0]  xprod_s99;
	logic signed [66:0]  yprod_s99;
	logic signed [34:0]  zv_s99;

	logic signed [34:0]  v_lane [0:2];
	logic [29:0]         u_s100 [0:2];
	logic                neg_s100 [0:2];
	logic [60:0]         qm_s101 [0:2];
	logic [29:0]         u_s101 [0:2];
	logic                neg_s101 [0:2];
	logic [24:0]         res_s102 [0:2];

	// whole pipeline moves unless a result is held at the output
	assign adv           = !vld_q[g2e_pkg::LAT] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[g2e_pkg::LAT];

	assign lat_in = s_axis_tdata[30:0];
	assign lon_in = s_axis_tdata[62:31];
	assign h_in   = s_axis_tdata[83:63];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= g2e_pkg::LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[1] <= s_axis_tvalid;
			for (int i = 2; i <= g2e_pkg::LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// sine and cosine of both angles, stages 1 to 30
	g2e_cordic u_cordic_lat (
		.clk     (clk),
		.en      (adv),
		.angle   (32'(lat_in)),
		.cos_q30 (clat),
		.sin_q30 (slat)
	);

	g2e_cordic u_cordic_lon (
		.clk     (clk),
		.en      (adv),
		.angle   (lon_in),
		.cos_q30 (clon),
		.sin_q30 (slon)
	);

	// height and trig delay lines
	always_ff @(posedge clk) begin
		if (adv) begin
			h_s[1] <= h_in;
			for (int i = 2; i <= g2e_pkg::ST_ROOT; i++) begin
				h_s[i] <= h_s[i-1];
			end
			trig_s[g2e_pkg::ST_TRIG+1] <= '{clat: clat, slat: slat, clon: clon, slon: slon};
			for (int i = g2e_pkg::ST_TRIG + 2; i <= 98; i++) begin
				trig_s[i] <= trig_s[i-1];
			end
		end
	end

	// stage 31: sin^2 of latitude, stage 32: 1 - e2*sin^2
	assign abs_s    = slat[31] ? 31'(-slat) : slat[30:0];
	assign sq_full  = 62'(abs_s) * 62'(abs_s);
	assign e2s_full = 56'(s2_s31) * 56'(g2e_pkg::E2_Q32);

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_s31 <= sq_full[60:30];
			w_s32  <= 31'(1 << 30) - 31'(e2s_full[55:32]);
		end
	end

	// stages 33 to 96: root and radius division
	g2e_root_div u_root_div (
		.clk    (clk),
		.en     (adv),
		.w_q30  (w_s32),
		.radius (n_rad)
	);

	// stage 97: radius plus height, and n*e2
	always_ff @(posedge clk) begin
		if (adv) begin
			prad_s97 <= 35'(n_rad) + 35'($signed({h_s[g2e_pkg::ST_ROOT], 3'b000}));
			ne2_s97  <= 58'(n_rad) * 58'(g2e_pkg::E2_Q32);
			n_s97    <= n_rad;
			h8_s97   <= {h_s[g2e_pkg::ST_ROOT], 3'b000};
		end
	end

	// stage 98: latitude products
	assign zrad = 35'(n_s97) - 35'(ne2_s97[57:32]) + 35'(h8_s97);

	always_ff @(posedge clk) begin
		if (adv) begin
			rprod_s98 <= 67'(prad_s97) * 67'(trig_s[97].clat);
			zprod_s98 <= 67'(zrad) * 67'(trig_s[97].slat);
		end
	end

	// stage 99: longitude products
	assign rho = rprod_s98[64:30];

	always_ff @(posedge clk) begin
		if (adv) begin
			xprod_s99 <= 67'(rho) * 67'(trig_s[98].clon);
			yprod_s99 <= 67'(rho) * 67'(trig_s[98].slon);
			zv_s99    <= zprod_s98[64:30];
		end
	end

	assign v_lane[0] = xprod_s99[64:30];
	assign v_lane[1] = yprod_s99[64:30];
	assign v_lane[2] = zv_s99;

	// stages 100 to 102: add offset, divide magnitude by 800, saturate
	for (genvar k = 0; k < 3; k++) begin : g_lane
		logic signed [35:0] t;
		logic [35:0]        mag;
		logic [25:0]        q0;
		logic [30:0]        rem;
		logic [25:0]        q;
		logic signed [26:0] sres;
		logic signed [26:0] sat;

		assign t   = 36'(v_lane[k]) + g2e_pkg::OFFSET_EIGHTHS;
		assign mag = t[35] ? 36'(-t) : 36'(t);

		assign q0   = qm_s101[k][60:g2e_pkg::RECIP_SHIFT];
		assign rem  = 31'(u_s101[k]) - 31'(q0) * 31'd25;
		assign q    = (rem >= 31'd25) ? q0 + 26'd1 : q0;
		assign sres = neg_s101[k] ? -(27'(q)) : 27'(q);

		always_comb begin
			if (sres < g2e_pkg::OUT_LOW) begin
				sat = g2e_pkg::OUT_LOW;
			end else if (sres > g2e_pkg::OUT_HIGH) begin
				sat = g2e_pkg::OUT_HIGH;
			end else begin
				sat = sres;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				u_s100[k]   <= mag[34:5];
				neg_s100[k] <= t[35];
				qm_s101[k]  <= 61'(u_s100[k]) * 61'(g2e_pkg::RECIP_25);
				u_s101[k]   <= u_s100[k];
				neg_s101[k] <= neg_s100[k];
				res_s102[k] <= sat[24:0];
			end
		end
	end

	assign m_axis_tdata = {5'b00000, res_s102[2], res_s102[1], res_s102[0]};

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for geodetic_to_ecef_offset
// depends on g2e_pkg (sizes, stage numbers and the arctangent table) and the geodetic_to_ecef_offset top level
// points are predicted in fixed point and results compared field by field

`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic signed [20:0] height;
		logic signed [31:0] longitude;
		logic signed [30:0] latitude;
	} point_t;

	typedef struct packed {
		logic signed [24:0] z_offset;
		logic signed [24:0] y_offset;
		logic signed [24:0] x_offset;
	} ecef_t;

	localparam int     N_RANDOM  = 400;
	localparam longint E2        = 64'd28752143;
	localparam longint OFS_8THS  = 64'd5102509600;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;

	point_t pending_points[$];
	ecef_t  expected_ecef[$];
	int     mismatches;
	bit     stimulus_done;
	bit     hold_off;
	bit     rx_stall_long;
	bit     in_taken;

	geodetic_to_ecef_offset u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// append a point to the pending queue
	function automatic void queue_point(point_t p);
		pending_points.insert(pending_points.size(), p);
	endfunction

	// rotation sine/cosine of an angle in 1e-7 degree, q30
	task automatic rotate_angle(input longint ang, output longint c, output longint s);
		longint r, x, y, z, dx, dy;
		bit     flip;
		r = ang % 64'sd3600000000;
		flip = 1'b0;
		if (r < 0) r += 64'sd3600000000;
		if (r > 64'sd1800000000) r -= 64'sd3600000000;
		if (r > 64'sd900000000) begin
			r -= 64'sd1800000000;
			flip = 1'b1;
		end else if (r < -64'sd900000000) begin
			r += 64'sd1800000000;
			flip = 1'b1;
		end
		x = 64'sd652032874;
		y = 0;
		z = r;
		for (int i = 0; i < g2e_pkg::CORDIC_STEPS; i++) begin
			dx = floor_sh(y, i);
			dy = floor_sh(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(g2e_pkg::atan_1e7deg(i));
			end else begin
				x += dx; y -= dy; z += longint'(g2e_pkg::atan_1e7deg(i));
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clamp(x, -64'sd1073741824, 64'sd1073741824);
		s = clamp(y, -64'sd1073741824, 64'sd1073741824);
	endtask

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [24:0] to_metres(longint eighths);
		longint m;
		m = (eighths + OFS_8THS) / 800;
		return 25'(clamp(m, -64'sd1048576, 64'sd16777215));
	endfunction

	task automatic predict_ecef(input point_t p, output ecef_t e);
		longint clat, slat, clon, slon, abs_s, nrad, prad, zrad, rho, h8;
		longint unsigned s2, w, root;
		rotate_angle(longint'(p.latitude), clat, slat);
		rotate_angle(longint'(p.longitude), clon, slon);
		h8 = longint'(p.height) * 8;
		abs_s = slat < 0 ? -slat : slat;
		s2 = (longint'(abs_s) * abs_s) >> 30;
		w = 64'd1073741824 - ((E2 * s2) >> 32);
		root = int_sqrt(w << 30);
		nrad = longint'((64'd637813700 << 33) / root);
		prad = nrad + h8;
		zrad = nrad - longint'((longint'(nrad) * E2) >> 32) + h8;
		rho = floor_sh(prad * clat, 30);
		e.x_offset = to_metres(floor_sh(rho * clon, 30));
		e.y_offset = to_metres(floor_sh(rho * slon, 30));
		e.z_offset = to_metres(floor_sh(zrad * slat, 30));
	endtask

	function automatic point_t mk(longint la, longint lo, longint h);
		point_t p;
		p.latitude  = 31'(la);
		p.longitude = 32'(lo);
		p.height    = 21'(h);
		return p;
	endfunction

	// random field values, mostly in range, some raw bit patterns
	function automatic point_t rand_point();
		point_t p;
		if ($urandom_range(0, 9) == 0)
			p = 84'({$urandom(), $urandom(), $urandom()});
		else
			p = mk(longint'($urandom_range(0, 1800000000)) - 900000000,
				longint'($urandom_range(0, 2000000000))
					+ longint'($urandom_range(0, 1600000000)) - 1800000000,
				longint'($urandom_range(0, 1100000)) - 100000);
		return p;
	endfunction

	// input transaction: predict and retire the queue head at the accepting edge
	always @(posedge clk) begin
		ecef_t e;
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_taken) begin
			predict_ecef(point_t'(s_axis_tdata[83:0]), e);
			expected_ecef.insert(expected_ecef.size(), e);
			void'(pending_points.pop_front());
		end
	end

	// driver: offer the queue head, change at the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (!s_axis_tvalid || in_taken) begin
				if (pending_points.size() != 0 && !hold_off
						&& ($urandom_range(0, 3) != 0 || rx_stall_long)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= 88'(pending_points[0]);
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready: short and occasional long stalls
	int rx_wait;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait       = 0;
		end else if (rx_stall_long) begin
			m_axis_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			rx_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= 1'b1;
	end

	// monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		ecef_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = ecef_t'(m_axis_tdata[74:0]);
			if (expected_ecef.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				mismatches++;
			end else begin
				want = expected_ecef.pop_front();
				if (got.x_offset !== want.x_offset) begin
					$display("%0t: x_offset expected %0d actual %0d", $time,
						want.x_offset, got.x_offset);
					mismatches++;
				end
				if (got.y_offset !== want.y_offset) begin
					$display("%0t: y_offset expected %0d actual %0d", $time,
						want.y_offset, got.y_offset);
					mismatches++;
				end
				if (got.z_offset !== want.z_offset) begin
					$display("%0t: z_offset expected %0d actual %0d", $time,
						want.z_offset, got.z_offset);
					mismatches++;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		mismatches    = 0;
		stimulus_done = 1'b0;
		hold_off      = 1'b0;
		rx_stall_long = 1'b0;
		arst_n        = 1'b0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// field extremes, poles, wraps, out-of-range latitude and height
		queue_point(mk(0, 0, 0));
		queue_point(mk(900000000, 0, 0));
		queue_point(mk(-900000000, 0, 0));
		queue_point(mk(0, 1800000000, 1000000));
		queue_point(mk(0, -1800000000, -100000));
		queue_point(mk(0, 900000000, 0));
		queue_point(mk(0, -900000000, 0));
		queue_point(mk(450000000, 450000000, 500000));
		queue_point(mk(-450000000, -1350000000, 0));
		queue_point(mk(1073741823, 0, 0));
		queue_point(mk(-1073741824, 0, 0));
		queue_point(mk(1200000000, 2147483647, 0));
		queue_point(mk(0, -2147483648, 0));
		queue_point(mk(0, 0, 1048575));
		queue_point(mk(0, 0, -1048576));
		queue_point(mk(900000000, 0, 1048575));
		queue_point(mk(-900000000, 1800000000, -1048576));
		queue_point(mk(-1, -1, -1));
		queue_point(mk(1, 1, 1));

		// first batch of random points
		repeat (N_RANDOM * 3 / 8) queue_point(rand_point());
		wait (pending_points.size() == 0);

		// receiver holds off long while the sender keeps offering
		repeat (N_RANDOM * 3 / 8) queue_point(rand_point());
		@(negedge clk);
		rx_stall_long = 1'b1;
		repeat (400) @(posedge clk);
		@(negedge clk);
		rx_stall_long = 1'b0;
		wait (pending_points.size() == 0);

		// sender pauses until every result is back
		hold_off = 1'b1;
		wait (expected_ecef.size() == 0 && !s_axis_tvalid);
		hold_off = 1'b0;
		repeat (N_RANDOM / 5) queue_point(rand_point());
		wait (pending_points.size() == 0);
		@(posedge clk);
		wait (expected_ecef.size() == 0);
		repeat (g2e_pkg::LAT + 20) @(posedge clk);
		if (mismatches == 0 && expected_ecef.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// timeout
	initial begin
		#5ms;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hdl/g2e_pkg.sv
hdl/g2e_cordic.sv
hdl/g2e_root_div.sv
hdl/geodetic_to_ecef_offset.sv
tb/testbench.sv
